// ----- sv/golu_pkg.sv -----
// Shared constants and types of the gain/offset linear upsampler.
package golu_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FACTOR  = 64;
  localparam int VALUE_W     = 32;
  localparam int FACTOR_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int DIFF_W      = VALUE_W + 1;
  localparam int PROD_W      = SAMPLE_BITS + VALUE_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int DIV_STEPS   = DIFF_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_BIAS   = 2'd1,
    REG_FACTOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] gain;
    logic signed [VALUE_W-1:0] bias;
    logic [FACTOR_W-1:0]       factor;
  } cfg_t;

  // One queued item: endpoints plus |cur-prev| / factor split into quotient and remainder.
  typedef struct packed {
    logic [VALUE_W-1:0]  prev;
    logic [VALUE_W-1:0]  cur;
    logic [DIFF_W-1:0]   qa;
    logic [FACTOR_W-1:0] ra;
    logic                neg;
    logic                have_prev;
    logic [FACTOR_W-1:0] f;
  } job_t;

endpackage

// ----- sv/golu_sample_if.sv -----
// Input sample channel.
interface golu_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [golu_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/golu_result_if.sv -----
// Result channel: scaled or interpolated value with flags.
interface golu_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [golu_pkg::VALUE_W-1:0] value;
  logic                                is_sample;
  logic                                last;

  modport source (output valid, output value, output is_sample, output last, input ready);
  modport sink (input valid, input value, input is_sample, input last, output ready);
endinterface

// ----- sv/golu_front.sv -----
// Front end: scale and saturate each sample, divide the step by the factor, queue the item.
module golu_front (
  input  logic              clk,
  input  logic              rst,
  input  golu_pkg::cfg_t    cfg,
  golu_sample_if.sink       sample_ch,
  output golu_pkg::job_t    job,
  output logic              job_push,
  input  logic              job_full
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SAT, F_ABS, F_DIV, F_PUSH} state_t;

  localparam int VW = golu_pkg::VALUE_W;
  localparam int DW = golu_pkg::DIFF_W;
  localparam int FW = golu_pkg::FACTOR_W;

  state_t                                  state;
  logic signed [golu_pkg::SAMPLE_BITS-1:0] s_reg;
  logic [FW-1:0]                           f_reg;
  logic signed [golu_pkg::PROD_W-1:0]      prod;
  logic [VW-1:0]                           cur;
  logic [VW-1:0]                           prev;
  logic                                    have_prev;
  logic                                    neg;
  logic [DW-1:0]                           dq;
  logic [FW-1:0]                           rem;
  logic [golu_pkg::DIV_CNT_W-1:0]          cnt;

  logic [FW-1:0]                 f_eff;
  logic [golu_pkg::SUM_W-1:0]    sum;
  logic [golu_pkg::SUM_W-VW:0]   sum_top;
  logic [VW-1:0]                 sat_cur;
  logic [DW-1:0]                 diff;
  logic [DW-1:0]                 mag;
  logic [FW:0]                   rem_s;
  logic [FW:0]                   rem_sub;
  logic                          ge;

  always_comb begin
    if (cfg.factor == '0) begin
      f_eff = FW'(1);
    end else if (cfg.factor > FW'(golu_pkg::MAX_FACTOR)) begin
      f_eff = FW'(golu_pkg::MAX_FACTOR);
    end else begin
      f_eff = cfg.factor;
    end
  end

  // Clamp the exact sum to the signed 32-bit range.
  always_comb begin
    sum = {prod[golu_pkg::PROD_W-1], prod}
        + {{(golu_pkg::SUM_W-VW){cfg.bias[VW-1]}}, cfg.bias};
    sum_top = sum[golu_pkg::SUM_W-1:VW-1];
    if ((&sum_top) || ~(|sum_top)) begin
      sat_cur = sum[VW-1:0];
    end else if (sum[golu_pkg::SUM_W-1]) begin
      sat_cur = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_cur = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_comb begin
    diff = {cur[VW-1], cur} - {prev[VW-1], prev};
    mag  = diff[DW-1] ? (~diff + DW'(1)) : diff;
  end

  // One restoring division step per cycle.
  always_comb begin
    rem_s   = {rem, dq[DW-1]};
    rem_sub = rem_s - {1'b0, f_reg};
    ge      = rem_s >= {1'b0, f_reg};
  end

  assign sample_ch.ready = (state == F_IDLE);
  assign job_push        = (state == F_PUSH) && !job_full;
  assign job.prev        = prev;
  assign job.cur         = cur;
  assign job.qa          = dq;
  assign job.ra          = rem;
  assign job.neg         = neg;
  assign job.have_prev   = have_prev;
  assign job.f           = f_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      prev      <= '0;
      have_prev <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (sample_ch.valid) begin
            s_reg <= sample_ch.sample;
            f_reg <= f_eff;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod  <= s_reg * cfg.gain;
          state <= F_SAT;
        end
        F_SAT: begin
          cur   <= sat_cur;
          state <= F_ABS;
        end
        F_ABS: begin
          neg   <= diff[DW-1];
          dq    <= mag;
          rem   <= '0;
          cnt   <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          dq  <= {dq[DW-2:0], ge};
          rem <= ge ? rem_sub[FW-1:0] : rem_s[FW-1:0];
          cnt <= cnt + 1'b1;
          if (cnt == golu_pkg::DIV_CNT_W'(golu_pkg::DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          // Hold until the queue has room.
          if (!job_full) begin
            prev      <= cur;
            have_prev <= 1'b1;
            state     <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/golu_queue.sv -----
// Short queue of items between front and back end.
module golu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  golu_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output golu_pkg::job_t pop_job,
  output logic           empty
);

  golu_pkg::job_t                  mem [golu_pkg::QUEUE_DEPTH];
  logic [golu_pkg::QPTR_W-1:0]     wr_ptr;
  logic [golu_pkg::QPTR_W-1:0]     rd_ptr;
  logic [golu_pkg::QCNT_W-1:0]     count;

  assign full    = (count == golu_pkg::QCNT_W'(golu_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/golu_back.sv -----
// Back end: walk the interpolated points of one item, then the sample itself.
module golu_back (
  input  logic           clk,
  input  logic           rst,
  input  golu_pkg::job_t job,
  input  logic           job_empty,
  output logic           job_pop,
  golu_result_if.source  result_ch
);

  typedef enum logic {B_IDLE, B_RUN} state_t;

  localparam int VW = golu_pkg::VALUE_W;
  localparam int DW = golu_pkg::DIFF_W;
  localparam int FW = golu_pkg::FACTOR_W;

  state_t          state;
  golu_pkg::job_t  cj;
  logic [FW-1:0]   j;
  logic [DW-1:0]   acc_q;
  logic [FW-1:0]   acc_r;
  logic            out_valid;
  logic [VW-1:0]   out_value;
  logic            out_is_sample;
  logic            out_last;

  logic            out_load;
  logic [VW+1:0]   ext_prev;
  logic [VW+1:0]   qx;
  logic [VW+1:0]   point;
  logic [FW:0]     r2;
  logic [FW:0]     r2_sub;
  logic            wrap;
  logic [DW:0]     qsum;

  always_comb begin
    ext_prev = {{2{cj.prev[VW-1]}}, cj.prev};
    qx       = {1'b0, acc_q};
    point    = cj.neg ? (ext_prev - qx) : (ext_prev + qx);
    r2       = {1'b0, acc_r} + {1'b0, cj.ra};
    r2_sub   = r2 - {1'b0, cj.f};
    wrap     = r2 >= {1'b0, cj.f};
    qsum     = {1'b0, acc_q} + {1'b0, cj.qa} + (DW+1)'(wrap);
  end

  assign out_load            = !out_valid || result_ch.ready;
  assign job_pop             = (state == B_IDLE) && !job_empty;
  assign result_ch.valid     = out_valid;
  assign result_ch.value     = out_value;
  assign result_ch.is_sample = out_is_sample;
  assign result_ch.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (out_load) begin
            out_valid <= 1'b0;
          end
          if (!job_empty) begin
            cj    <= job;
            j     <= FW'(1);
            acc_q <= job.qa;
            acc_r <= job.ra;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (cj.have_prev && (j < cj.f)) begin
              out_value     <= point[VW-1:0];
              out_is_sample <= 1'b0;
              out_last      <= 1'b0;
              // Advance the running quotient of j*|diff|/f.
              j     <= j + 1'b1;
              acc_q <= qsum[DW-1:0];
              acc_r <= wrap ? r2_sub[FW-1:0] : r2[FW-1:0];
            end else begin
              out_value     <= cj.cur;
              out_is_sample <= 1'b1;
              out_last      <= 1'b1;
              state         <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/gain_offset_linear_upsampler_top.sv -----
// Top level: configuration registers, front end, item queue and back end.
//
// Usage: samples enter on sample_ch (valid/ready). Each is scaled to
// sample*gain+bias in Q16.16 and clamped to 32 bits. Every sample after the
// first produces factor-1 linearly interpolated points on result_ch (factor
// 0 acts as 1, above 64 as 64), then the scaled sample (is_sample=1,
// last=1). The first sample after reset produces only its scaled value.
// The delay from an accepted sample to its first result is set mostly by
// the 1-bit-per-cycle divider (33 steps). The front end takes a new sample
// only after it has pushed the previous item; the back end emits one result
// per cycle while the receiver is ready, then returns to idle to pick up the
// next queued item. A two-entry queue lets the front end work on the next
// sample while the back end emits.
// Registers are written on cfg_we with cfg_index: 0 gain, 1 bias, 2 factor;
// other indexes are ignored. Write them only while the block is idle.
// Reset (rst, synchronous): gain 1.0, bias 0, factor 1, no previous sample.
// A stalled receiver holds the output register; the queue then fills and
// sample_ch.ready drops until results drain.
module gain_offset_linear_upsampler_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [golu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [golu_pkg::CFG_DATA_W-1:0]    cfg_data,
  golu_sample_if.sink                        sample_ch,
  golu_result_if.source                      result_ch
);

  golu_pkg::cfg_t cfg;
  golu_pkg::job_t push_job;
  golu_pkg::job_t pop_job;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= golu_pkg::VALUE_W'(65536);
      cfg.bias   <= '0;
      cfg.factor <= golu_pkg::FACTOR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        golu_pkg::REG_GAIN:   cfg.gain   <= cfg_data[golu_pkg::VALUE_W-1:0];
        golu_pkg::REG_BIAS:   cfg.bias   <= cfg_data[golu_pkg::VALUE_W-1:0];
        golu_pkg::REG_FACTOR: cfg.factor <= cfg_data[golu_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  golu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .job       (push_job),
    .job_push  (push),
    .job_full  (full)
  );

  golu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  golu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_job),
    .job_empty (empty),
    .job_pop   (pop),
    .result_ch (result_ch)
  );

endmodule

// ----- verif/tb_gain_offset_linear_upsampler_top.sv -----
// Self-checking regression for the gain/offset linear upsampler top level.
module tb_gain_offset_linear_upsampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 45;
  localparam int END_CYCLES    = 60;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 30;
  localparam logic [golu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [golu_pkg::VALUE_W-1:0] value;
    logic                                is_sample;
    logic                                last;
  } point_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [golu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [golu_pkg::CFG_DATA_W-1:0] cfg_data;

  golu_sample_if sample_ch ();
  golu_result_if result_ch ();

  gain_offset_linear_upsampler_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Mirror of the block's registers and interpolation state.
  logic signed [golu_pkg::VALUE_W-1:0] gain_q;
  logic signed [golu_pkg::VALUE_W-1:0] bias_q;
  logic [golu_pkg::FACTOR_W-1:0]       factor_q;
  logic signed [golu_pkg::VALUE_W-1:0] prev_value;
  logic                                have_prev;

  point_t expected_points[$];
  point_t head_point;

  int errors;
  int samples_sent;
  int results_seen;
  int settings_used;
  int rx_wait;
  int stall_cycles;
  bit tx_idle_en;
  bit rx_idle_en;

  always #10 clk = ~clk;

  // Receiver: hold ready low for the drawn number of cycles after each item.
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      result_ch.ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      rx_wait = rx_idle_en ? $urandom_range(0, 3) : 0;
      results_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected item: value=%0d is_sample=%0b last=%0b", $time,
                 result_ch.value, result_ch.is_sample, result_ch.last);
        errors++;
      end else begin
        head_point = expected_points.pop_front();
        if (result_ch.value !== head_point.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d", $time,
                   head_point.value, result_ch.value);
          errors++;
        end
        if (result_ch.is_sample !== head_point.is_sample) begin
          $display("%0t: is_sample mismatch: expected %0b actual %0b", $time,
                   head_point.is_sample, result_ch.is_sample);
          errors++;
        end
        if (result_ch.last !== head_point.last) begin
          $display("%0t: last mismatch: expected %0b actual %0b", $time,
                   head_point.last, result_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d items still expected", $time,
               STALL_LIMIT, expected_points.size());
      $display("gain_offset_linear_upsampler_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [golu_pkg::VALUE_W-1:0] scale_sample(
    input logic signed [golu_pkg::SAMPLE_BITS-1:0] s
  );
    longint full;
    full = longint'(s) * longint'(gain_q) + longint'(bias_q);
    if (full > 64'sh7FFF_FFFF) full = 64'sh7FFF_FFFF;
    if (full < -64'sh8000_0000) full = -64'sh8000_0000;
    return full[golu_pkg::VALUE_W-1:0];
  endfunction

  // Append one expected item at the tail of the queue.
  function automatic void queue_point(input logic [golu_pkg::VALUE_W-1:0] value,
                                      input logic is_sample, input logic last);
    point_t p;
    p.value     = value;
    p.is_sample = is_sample;
    p.last      = last;
    expected_points.insert(expected_points.size(), p);
  endfunction

  // Queue the interpolated points and the scaled sample caused by s.
  task automatic upsample_predict(input logic signed [golu_pkg::SAMPLE_BITS-1:0] s);
    logic signed [golu_pkg::VALUE_W-1:0] cur;
    longint diff;
    longint pt;
    int steps;
    cur = scale_sample(s);
    steps = int'(factor_q);
    if (steps < 1) steps = 1;
    if (steps > golu_pkg::MAX_FACTOR) steps = golu_pkg::MAX_FACTOR;
    if (have_prev) begin
      diff = longint'(cur) - longint'(prev_value);
      for (int j = 1; j < steps; j++) begin
        pt = longint'(prev_value) + (longint'(j) * diff) / longint'(steps);
        queue_point(pt[golu_pkg::VALUE_W-1:0], 1'b0, 1'b0);
      end
    end
    queue_point(cur, 1'b1, 1'b1);
    prev_value = cur;
    have_prev = 1'b1;
  endtask

  // Drive one item; return at the edge where it is accepted, valid left high.
  task automatic send_sample(input logic signed [golu_pkg::SAMPLE_BITS-1:0] s);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    upsample_predict(s);
    samples_sent++;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Drop valid, wait for every expected item, then let the pipeline go quiet.
  task automatic drain_and_pause();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes need no toggle; end_writes lowers it.
  task automatic write_reg(input logic [golu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [golu_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      golu_pkg::REG_GAIN:   gain_q = data;
      golu_pkg::REG_BIAS:   bias_q = data;
      golu_pkg::REG_FACTOR: factor_q = data[golu_pkg::FACTOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] g, input logic [31:0] b, input logic [6:0] f);
    write_reg(golu_pkg::REG_GAIN, g);
    write_reg(golu_pkg::REG_BIAS, b);
    write_reg(golu_pkg::REG_FACTOR, {25'd0, f});
    end_writes();
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    drain_and_pause();
  endtask

  task automatic test_saturation();
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd1);
    drain_and_pause();
    set_config(32'h8000_0000, 32'h8000_0000, 7'd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    drain_and_pause();
  endtask

  // Swing between the saturation rails so the interpolation difference is widest.
  task automatic test_factor_limits();
    set_config(32'h7FFF_FFFF, 32'h0, 7'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_and_pause();
    set_config(32'h7FFF_FFFF, 32'h0, 7'd2);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_and_pause();
    set_config(32'h7FFF_FFFF, 32'h0, 7'd64);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_and_pause();
    set_config(32'h7FFF_FFFF, 32'h0, 7'd65);
    send_sample(16'sh7FFF);
    drain_and_pause();
    set_config(32'h7FFF_FFFF, 32'h0, 7'd127);
    send_sample(16'sh8000);
    drain_and_pause();
  endtask

  task automatic test_unknown_index();
    set_config(32'h0001_8000, 32'hFFFF_0000, 7'd3);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    end_writes();
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    drain_and_pause();
  endtask

  task automatic test_random();
    logic [31:0] g;
    logic [31:0] b;
    logic [6:0]  f;
    logic [15:0] s;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: g = $urandom();
        1: g = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        2: g = 32'h0001_0000;
        default: g = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
      b = ($urandom_range(0, 1) == 0) ? $urandom() :
          $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      // Mostly small factors; now and then the clamped and zero cases.
      case ($urandom_range(0, 9))
        0: f = 7'd0;
        1: f = 7'($urandom_range(64, 127));
        2: f = 7'($urandom_range(9, 63));
        default: f = 7'($urandom_range(1, 8));
      endcase
      set_config(g, b, f);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          default: s = 16'($urandom());
        endcase
        send_sample(s);
      end
      drain_and_pause();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    gain_q = 32'sh0001_0000;
    bias_q = '0;
    factor_q = 7'd1;
    prev_value = '0;
    have_prev = 1'b0;
    errors = 0;
    samples_sent = 0;
    results_seen = 0;
    settings_used = 1;
    rx_wait = 0;
    stall_cycles = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_saturation();
    test_factor_limits();
    test_unknown_index();
    test_random();

    while (expected_points.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d samples, %0d results checked, over %0d register settings.",
             samples_sent, results_seen, settings_used);
    $display("Factors 0, 1, 2, 64 and above, rail-to-rail saturation and ignored writes.");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("gain_offset_linear_upsampler_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d items never arrived", errors, expected_points.size());
      $display("gain_offset_linear_upsampler_top regression: fail");
    end
    $finish;
  end

endmodule
